>>> rtl/ttyld_pkg.sv
// Shared types, codes and character helpers for the terminal line discipline.
`default_nettype none
package ttyld_pkg;

	typedef enum logic [2:0] {
		OUT_ECHO    = 3'd0,
		OUT_RUBOUTS = 3'd1,
		OUT_SIGNAL  = 3'd2,
		OUT_STOP    = 3'd3,
		OUT_START   = 3'd4,
		OUT_COOKED  = 3'd5,
		OUT_EMPTY   = 3'd6,
		OUT_REFUSED = 3'd7
	} out_kind_t;

	typedef enum logic [2:0] {
		REG_INPUT_MODE     = 3'd0,
		REG_LOCAL_MODE     = 3'd1,
		REG_EDIT_CHARS     = 3'd2,
		REG_SIGNAL_CHARS   = 3'd3,
		REG_FLOW_CHARS     = 3'd4,
		REG_GROUP_ORPHANED = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		ITEM_RAW = 1'b0,
		ITEM_POP = 1'b1
	} item_kind_t;

	localparam logic [7:0] SIG_INT  = 8'd0;
	localparam logic [7:0] SIG_QUIT = 8'd1;
	localparam logic [7:0] SIG_SUSP = 8'd2;

	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_UPPER_A = 8'd65;
	localparam logic [7:0] CH_UPPER_Z = 8'd90;
	localparam logic [7:0] CARET_OFFSET = 8'd64;
	localparam logic [7:0] CASE_OFFSET  = 8'd32;

	localparam logic [4:0]  INPUT_MODE_RST   = 5'd1;
	localparam logic [3:0]  LOCAL_MODE_RST   = 4'd15;
	localparam logic [23:0] EDIT_CHARS_RST   = 24'h04157F;
	localparam logic [23:0] SIGNAL_CHARS_RST = 24'h1A1C03;
	localparam logic [15:0] FLOW_CHARS_RST   = 16'h1311;

	localparam logic [9:0]  LINE_MAX   = 10'd1023;
	localparam logic [10:0] RUBOUT_MAX = 11'd2047;

	// A special character of zero is disabled.
	function automatic logic char_match(input logic [7:0] c, input logic [7:0] k);
		char_match = (k != 8'd0) && (c == k);
	endfunction

endpackage
`default_nettype wire

>>> rtl/ttyld_if.sv
// Channel interfaces: raw item input, result output and configuration writes.
`default_nettype none
interface ttyld_item_if;
	import ttyld_pkg::*;
	logic       valid;
	logic       ready;
	item_kind_t kind;
	logic [7:0] raw_byte;
	modport source (output valid, kind, raw_byte, input ready);
	modport sink   (input valid, kind, raw_byte, output ready);
endinterface

interface ttyld_result_if;
	import ttyld_pkg::*;
	logic        valid;
	logic        ready;
	out_kind_t   out_kind;
	logic [7:0]  value;
	logic [10:0] rubout_count;
	logic        line_end;
	logic [9:0]  lines_pending;
	logic        last_result;
	modport source (output valid, out_kind, value, rubout_count, line_end,
		lines_pending, last_result, input ready);
	modport sink   (input valid, out_kind, value, rubout_count, line_end,
		lines_pending, last_result, output ready);
endinterface

interface ttyld_cfg_if;
	import ttyld_pkg::*;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [23:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> rtl/ttyld_ring.sv
// Cooked byte ring storage: one write port, one read port with registered data.
`default_nettype none
module ttyld_ring #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

>>> rtl/tty_canonical_line_discipline.sv
// Canonical terminal input line discipline over a ring of cooked bytes.
//
// Takes raw received bytes and pop requests on the item channel and returns zero, one or two
// results per item on the result channel; configuration writes are accepted at any time the
// block is idle. The block works on one item at a time: the item channel is ready only while the
// sequencer is idle. A raw byte is latched, then decoded (and pushed), and each result then
// leaves through the output register; a pop reads the ring once before its result. Erase and
// kill walk back through the ring one byte at a time (a read of the ring's single read port,
// then a check) and stop at a line end or an empty ring, erase after one byte; with echo off
// they return no result.
// The ring holds up to QUEUE_DEPTH-1 bytes and needs no clearing after reset.
`default_nettype none
module tty_canonical_line_discipline #(
	parameter int QUEUE_DEPTH = 1024
) (
	input  logic clk,
	input  logic arst_n,
	ttyld_cfg_if.sink      cfg,
	ttyld_item_if.sink     item,
	ttyld_result_if.source result
);
	import ttyld_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_DECODE   = 6'b000010,
		S_RUB_RD   = 6'b000100,
		S_RUB_CHK  = 6'b001000,
		S_RUB_DONE = 6'b010000,
		S_EMIT     = 6'b100000
	} state_t;

	state_t state_q;

	// configuration
	logic [4:0]  input_mode_q;
	logic [3:0]  local_mode_q;
	logic [23:0] edit_chars_q;
	logic [23:0] signal_chars_q;
	logic [15:0] flow_chars_q;
	logic        group_orphaned_q;

	// ring control
	logic [PTR_W-1:0] head_q, tail_q, used_q;
	logic [9:0]       line_count_q;

	// latched item
	item_kind_t kind_q;
	logic [7:0] byte_q;

	// erase / kill walk
	logic        rub_one_q;
	logic        rub_done_one_q;
	logic        rub_echo_q;
	logic [10:0] rub_q;

	// pending results
	out_kind_t   res0_kind_q;
	logic [7:0]  res0_value_q;
	logic [10:0] res0_rub_q;
	logic        res0_le_q;
	logic [7:0]  res1_value_q;
	logic        res_two_q;
	logic        res_idx_q;

	// output register
	logic        out_valid_q;
	out_kind_t   out_kind_q;
	logic [7:0]  out_value_q;
	logic [10:0] out_rub_q;
	logic        out_le_q;
	logic [9:0]  out_lines_q;
	logic        out_last_q;

	logic [PTR_W-1:0] head_next, head_prev, tail_next, rd_addr;
	logic [7:0]       rd_data;
	logic             ring_full;
	logic             pop_empty;

	assign head_next = (head_q == LAST) ? '0 : head_q + 1'b1;
	assign head_prev = (head_q == '0) ? LAST : head_q - 1'b1;
	assign tail_next = (tail_q == LAST) ? '0 : tail_q + 1'b1;
	assign ring_full = (used_q == LAST);
	assign rd_addr   = (state_q == S_RUB_RD) ? head_prev : tail_q;
	assign pop_empty = (used_q == '0) || (local_mode_q[0] && line_count_q == '0 && !ring_full);

	// raw byte decode
	logic [7:0] c_map, c;
	logic       drop_cr, is_kill, is_erase, is_stop, is_start;
	logic       sig_int, sig_quit, sig_susp, c_line_end, c_ctrl, echo_on;
	logic       push_en;
	logic       rd_line_end;
	logic [11:0] rub_sum;

	always_comb begin
		c_map   = byte_q;
		drop_cr = 1'b0;
		if (byte_q == CH_CR) begin
			if (input_mode_q[0]) begin
				c_map = CH_LF;
			end else begin
				drop_cr = input_mode_q[2];
			end
		end else if (byte_q == CH_LF && input_mode_q[1]) begin
			c_map = CH_CR;
		end
		c = c_map;
		if (input_mode_q[3] && c_map >= CH_UPPER_A && c_map <= CH_UPPER_Z) begin
			c = c_map + CASE_OFFSET;
		end
	end

	assign echo_on    = local_mode_q[2];
	assign is_kill    = local_mode_q[0] && char_match(c, edit_chars_q[15:8]);
	assign is_erase   = local_mode_q[0] && char_match(c, edit_chars_q[7:0]);
	assign is_stop    = input_mode_q[4] && char_match(c, flow_chars_q[15:8]);
	assign is_start   = input_mode_q[4] && char_match(c, flow_chars_q[7:0]);
	assign sig_int    = local_mode_q[1] && char_match(c, signal_chars_q[7:0]);
	assign sig_quit   = local_mode_q[1] && char_match(c, signal_chars_q[15:8]);
	assign sig_susp   = local_mode_q[1] && char_match(c, signal_chars_q[23:16]);
	assign c_line_end = (c == CH_LF) || char_match(c, edit_chars_q[23:16]);
	assign c_ctrl     = (c < CH_SPACE);

	assign push_en = (state_q == S_DECODE) && (kind_q == ITEM_RAW) && !ring_full && !drop_cr
		&& !is_kill && !is_erase && !is_stop && !is_start
		&& !sig_int && !sig_quit && !sig_susp;

	assign rd_line_end = (rd_data == CH_LF) || char_match(rd_data, edit_chars_q[23:16]);
	assign rub_sum     = {1'b0, rub_q} + ((rd_data < CH_SPACE) ? 12'd2 : 12'd1);

	ttyld_ring #(
		.DEPTH (QUEUE_DEPTH),
		.AW    (PTR_W)
	) u_ring (
		.clk     (clk),
		.wr_en   (push_en),
		.wr_addr (head_q),
		.wr_data (c),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// configuration writes
	assign cfg.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_mode_q     <= INPUT_MODE_RST;
			local_mode_q     <= LOCAL_MODE_RST;
			edit_chars_q     <= EDIT_CHARS_RST;
			signal_chars_q   <= SIGNAL_CHARS_RST;
			flow_chars_q     <= FLOW_CHARS_RST;
			group_orphaned_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				REG_INPUT_MODE:     input_mode_q     <= cfg.data[4:0];
				REG_LOCAL_MODE:     local_mode_q     <= cfg.data[3:0];
				REG_EDIT_CHARS:     edit_chars_q     <= cfg.data;
				REG_SIGNAL_CHARS:   signal_chars_q   <= cfg.data;
				REG_FLOW_CHARS:     flow_chars_q     <= cfg.data[15:0];
				REG_GROUP_ORPHANED: group_orphaned_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	assign item.ready = (state_q == S_IDLE);

	logic out_free;
	assign out_free = !out_valid_q || result.ready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			head_q         <= '0;
			tail_q         <= '0;
			used_q         <= '0;
			line_count_q   <= '0;
			res_two_q      <= 1'b0;
			res_idx_q      <= 1'b0;
			rub_one_q      <= 1'b0;
			rub_done_one_q <= 1'b0;
			rub_echo_q     <= 1'b0;
			rub_q          <= '0;
			res0_kind_q    <= OUT_ECHO;
			res0_value_q   <= '0;
			res0_rub_q     <= '0;
			res0_le_q      <= 1'b0;
			res1_value_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (item.valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					res_idx_q  <= 1'b0;
					res_two_q  <= 1'b0;
					res0_rub_q <= '0;
					res0_le_q  <= (kind_q == ITEM_POP) && !pop_empty && rd_line_end;
					state_q    <= S_EMIT;
					if (kind_q == ITEM_POP) begin
						if (pop_empty) begin
							res0_kind_q  <= OUT_EMPTY;
							res0_value_q <= '0;
						end else begin
							tail_q       <= tail_next;
							used_q       <= used_q - 1'b1;
							res0_kind_q  <= OUT_COOKED;
							res0_value_q <= rd_data;
							if (rd_line_end && line_count_q != '0) begin
								line_count_q <= line_count_q - 1'b1;
							end
						end
					end else if (ring_full) begin
						res0_kind_q  <= OUT_REFUSED;
						res0_value_q <= '0;
					end else if (drop_cr) begin
						state_q <= S_IDLE;
					end else if (is_kill || is_erase) begin
						rub_one_q      <= !is_kill;
						rub_done_one_q <= 1'b0;
						rub_echo_q     <= echo_on;
						rub_q          <= '0;
						res0_value_q   <= '0;
						state_q        <= S_RUB_RD;
					end else if (is_stop) begin
						res0_kind_q  <= OUT_STOP;
						res0_value_q <= '0;
					end else if (is_start) begin
						res0_kind_q  <= OUT_START;
						res0_value_q <= '0;
					end else if (sig_int) begin
						res0_kind_q  <= OUT_SIGNAL;
						res0_value_q <= SIG_INT;
					end else if (sig_quit) begin
						res0_kind_q  <= OUT_SIGNAL;
						res0_value_q <= SIG_QUIT;
					end else if (sig_susp) begin
						res0_kind_q  <= OUT_SIGNAL;
						res0_value_q <= SIG_SUSP;
						if (group_orphaned_q) begin
							state_q <= S_IDLE;
						end
					end else begin
						// push and echo
						head_q <= head_next;
						used_q <= used_q + 1'b1;
						if (c_line_end && line_count_q != LINE_MAX) begin
							line_count_q <= line_count_q + 1'b1;
						end
						res0_kind_q <= OUT_ECHO;
						if (!echo_on) begin
							state_q <= S_IDLE;
						end else if (c == CH_LF) begin
							res0_value_q <= CH_LF;
							res1_value_q <= CH_CR;
							res_two_q    <= 1'b1;
						end else if (c_ctrl) begin
							res0_value_q <= CH_CARET;
							res1_value_q <= c + CARET_OFFSET;
							res_two_q    <= 1'b1;
							if (!local_mode_q[3]) begin
								state_q <= S_IDLE;
							end
						end else begin
							res0_value_q <= c;
						end
					end
				end
				S_RUB_RD: begin
					if (used_q == '0 || (rub_one_q && rub_done_one_q)) begin
						state_q <= S_RUB_DONE;
					end else begin
						state_q <= S_RUB_CHK;
					end
				end
				S_RUB_CHK: begin
					if (rd_line_end) begin
						state_q <= S_RUB_DONE;
					end else begin
						rub_q          <= rub_sum[11] ? RUBOUT_MAX : rub_sum[10:0];
						head_q         <= head_prev;
						used_q         <= used_q - 1'b1;
						rub_done_one_q <= 1'b1;
						state_q        <= S_RUB_RD;
					end
				end
				S_RUB_DONE: begin
					res0_kind_q <= OUT_RUBOUTS;
					res0_rub_q  <= rub_q;
					state_q     <= rub_echo_q ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (out_free) begin
						if (res_two_q && !res_idx_q) begin
							res_idx_q <= 1'b1;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// latch item payload
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item.valid) begin
			kind_q <= item.kind;
			byte_q <= item.raw_byte;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			out_lines_q <= line_count_q;
			if (res_idx_q) begin
				out_kind_q  <= OUT_ECHO;
				out_value_q <= res1_value_q;
				out_rub_q   <= '0;
				out_le_q    <= 1'b0;
				out_last_q  <= 1'b1;
			end else begin
				out_kind_q  <= res0_kind_q;
				out_value_q <= res0_value_q;
				out_rub_q   <= res0_rub_q;
				out_le_q    <= res0_le_q;
				out_last_q  <= !res_two_q;
			end
		end
	end

	assign result.valid         = out_valid_q;
	assign result.out_kind      = out_kind_q;
	assign result.value         = out_value_q;
	assign result.rubout_count  = out_rub_q;
	assign result.line_end      = out_le_q;
	assign result.lines_pending = out_lines_q;
	assign result.last_result   = out_last_q;

endmodule
`default_nettype wire
